// ----- sv/dynamic_connected_components_unit_defines.svh -----
// Assertion macros for the connected components unit.
`ifndef DYNAMIC_CONNECTED_COMPONENTS_UNIT_DEFINES_SVH
`define DYNAMIC_CONNECTED_COMPONENTS_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define DCC_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("dcc check failed");

// Next-cycle implication, sampled on aclk, off during reset.
`define DCC_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("dcc check failed");

`endif

// ----- sv/dcc_pkg.sv -----
`default_nettype none
package dcc_pkg;
    localparam int VERTEX_W         = 6;
    localparam int LABEL_W          = 6;
    localparam int COUNT_W          = 7;
    localparam int EDGE_W           = 12;
    localparam int MAX_VERTICES_DEF = 64;
    localparam int HW_VERTEX_CAP    = 64;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_NO_CHANGE = 2'd1;
    localparam logic [1:0] STATUS_RANGE     = 2'd2;

    localparam logic REG_VERTEX_COUNT = 1'b0;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } dcc_mem_ctrl_t;
endpackage
`default_nettype wire

// ----- sv/dcc_adj_mem.sv -----
`default_nettype none
module dcc_adj_mem #(
    parameter int DEPTH = dcc_pkg::MAX_VERTICES_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  dcc_pkg::dcc_mem_ctrl_t     ctrl,
    input  wire  [AW-1:0]              rd_addr,
    input  wire  [AW-1:0]              wr_addr,
    input  wire  [DEPTH-1:0]           wr_data,
    output logic [DEPTH-1:0]           rd_data
);
    logic [DEPTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] row_valid_reg;
    logic [DEPTH-1:0] rd_data_reg;
    logic             rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // An unwritten row reads as empty.
    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            if (ctrl.wr_en) begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (ctrl.rd_en) begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;
endmodule
`default_nettype wire

// ----- sv/dcc_label_mem.sv -----
`default_nettype none
module dcc_label_mem #(
    parameter int DEPTH = dcc_pkg::MAX_VERTICES_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  dcc_pkg::dcc_mem_ctrl_t       ctrl,
    input  wire  [AW-1:0]                rd0_addr,
    input  wire  [AW-1:0]                rd1_addr,
    input  wire  [AW-1:0]                wr_addr,
    input  wire  [dcc_pkg::LABEL_W-1:0]  wr_data,
    output logic [dcc_pkg::LABEL_W-1:0]  rd0_data,
    output logic [dcc_pkg::LABEL_W-1:0]  rd1_data
);
    logic [dcc_pkg::LABEL_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]            lbl_valid_reg;
    logic [dcc_pkg::LABEL_W-1:0] rd0_data_reg, rd1_data_reg;
    logic [AW-1:0]               rd0_addr_reg, rd1_addr_reg;
    logic                        rd0_valid_reg, rd1_valid_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en) begin
            rd0_data_reg <= mem[rd0_addr];
            rd1_data_reg <= mem[rd1_addr];
            rd0_addr_reg <= rd0_addr;
            rd1_addr_reg <= rd1_addr;
        end
    end

    // An unwritten entry reads as its own index.
    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            lbl_valid_reg <= '0;
            rd0_valid_reg <= 1'b0;
            rd1_valid_reg <= 1'b0;
        end else begin
            if (ctrl.wr_en) begin
                lbl_valid_reg[wr_addr] <= 1'b1;
            end
            if (ctrl.rd_en) begin
                rd0_valid_reg <= lbl_valid_reg[rd0_addr];
                rd1_valid_reg <= lbl_valid_reg[rd1_addr];
            end
        end
    end

    assign rd0_data = rd0_valid_reg ? rd0_data_reg : dcc_pkg::LABEL_W'(rd0_addr_reg);
    assign rd1_data = rd1_valid_reg ? rd1_data_reg : dcc_pkg::LABEL_W'(rd1_addr_reg);
endmodule
`default_nettype wire

// ----- sv/dynamic_connected_components_unit.sv -----
// Query and no-change items end after the adjacency and label reads; out-of-range skips them.
// Insert of a new edge sets both rows; merging two components rescans all vertex_count labels.
// Remove clears both rows, searches from vertex_a, and on a split relabels the vertices reached.
// One item at a time; the next input transfer follows the result hand-off.
// Reset (aresetn low, synchronous): vertex_count 64, empty graph, valid bits cleared at once.
`default_nettype none
module dynamic_connected_components_unit #(
    parameter int MAX_VERTICES = dcc_pkg::MAX_VERTICES_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // [1:0] mode, [7:2] vertex_a, [13:8] vertex_b
    input  wire  [15:0] s_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    // [1:0] status, [2] edge_present, [3] same_component, [9:4] component_a,
    // [15:10] component_b, [22:16] components_total, [34:23] edges_total
    output logic [39:0] m_tdata,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int VLIM = (MAX_VERTICES < dcc_pkg::HW_VERTEX_CAP) ?
                          MAX_VERTICES : dcc_pkg::HW_VERTEX_CAP;
    localparam int IW = $clog2(VLIM);
    localparam int CW = $clog2(VLIM + 1);
    localparam int VW = dcc_pkg::VERTEX_W;
    localparam int LW = dcc_pkg::LABEL_W;
    localparam int NW = dcc_pkg::COUNT_W;
    localparam int EW = dcc_pkg::EDGE_W;
    localparam logic [VLIM-1:0] ONE = VLIM'(1);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_EVAL    = 9'b000000010,
        S_ROWB_RD = 9'b000000100,
        S_ROWB_WR = 9'b000001000,
        S_MRD     = 9'b000010000,
        S_MWR     = 9'b000100000,
        S_PICK    = 9'b001000000,
        S_OR      = 9'b010000000,
        S_RELAB   = 9'b100000000
    } state_t;

    typedef struct packed {
        logic [1:0]    status;
        logic          edge_present;
        logic          same_component;
        logic [LW-1:0] component_a;
        logic [LW-1:0] component_b;
    } result_t;

    state_t              state_reg, state_next;
    logic [1:0]          mode_reg, mode_next;
    logic [VW-1:0]       a_reg, a_next, b_reg, b_next;
    logic [LW-1:0]       la_reg, la_next, lb_reg, lb_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [VLIM-1:0]     visited_reg, visited_next, expanded_reg, expanded_next;
    logic [NW-1:0]       vc_reg, vc_next, comp_reg, comp_next;
    logic [EW-1:0]       edges_reg, edges_next;
    result_t             res_reg, res_next;
    logic                pend_reg, pend_next;
    logic                out_valid_reg, out_valid_next;
    logic [39:0]         out_data_reg, out_data_next;

    dcc_pkg::dcc_mem_ctrl_t adj_ctrl, lbl_ctrl;
    logic [IW-1:0]       adj_rd_addr, adj_wr_addr, lbl_rd0_addr, lbl_rd1_addr, lbl_wr_addr;
    logic [VLIM-1:0]     adj_wr_data, adj_rd_data;
    logic [LW-1:0]       lbl_wr_data, lbl_rd0_data, lbl_rd1_data;

    logic                cfg_we;
    logic [NW-1:0]       cfg_vc;
    logic [1:0]          in_mode;
    logic [VW-1:0]       in_a, in_b;
    logic                in_range;
    logic                present;
    logic [LW-1:0]       lab_lo, lab_hi;
    logic [VLIM-1:0]     frontier;
    logic                pick_any;
    logic [IW-1:0]       pick_idx;
    logic                scan_end;

    assign in_mode = s_tdata[1:0];
    assign in_a    = s_tdata[7:2];
    assign in_b    = s_tdata[13:8];
    assign in_range = (NW'(in_a) < vc_reg) && (NW'(in_b) < vc_reg);

    assign cfg_we = psel && penable && pwrite && pready &&
                    (paddr[2] == dcc_pkg::REG_VERTEX_COUNT);
    assign cfg_vc = (pwdata[NW-1:0] > NW'(VLIM)) ? NW'(VLIM) : pwdata[NW-1:0];
    assign pready = 1'b1;
    assign prdata = 32'(vc_reg);

    assign present  = adj_rd_data[b_reg[IW-1:0]];
    assign lab_lo   = (la_reg < lb_reg) ? la_reg : lb_reg;
    assign lab_hi   = (la_reg < lb_reg) ? lb_reg : la_reg;
    assign frontier = visited_reg & ~expanded_reg;
    assign scan_end = (NW'(idx_reg) == vc_reg);

    always_comb begin
        pick_any = 1'b0;
        pick_idx = '0;
        for (int k = VLIM - 1; k >= 0; k--) begin
            if (frontier[k]) begin
                pick_any = 1'b1;
                pick_idx = IW'(k);
            end
        end
    end

    assign s_tready = (state_reg == S_IDLE) && !pend_reg;

    always_comb begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        la_next        = la_reg;
        lb_next        = lb_reg;
        idx_next       = idx_reg;
        visited_next   = visited_reg;
        expanded_next  = expanded_reg;
        vc_next        = vc_reg;
        comp_next      = comp_reg;
        edges_next     = edges_reg;
        res_next       = res_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        adj_ctrl     = '0;
        lbl_ctrl     = '0;
        adj_rd_addr  = a_reg[IW-1:0];
        adj_wr_addr  = a_reg[IW-1:0];
        adj_wr_data  = adj_rd_data;
        lbl_rd0_addr = in_a[IW-1:0];
        lbl_rd1_addr = in_b[IW-1:0];
        lbl_wr_addr  = idx_reg[IW-1:0];
        lbl_wr_data  = la_reg;

        if (m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    mode_next = in_mode;
                    a_next    = in_a;
                    b_next    = in_b;
                    if (!in_range) begin
                        res_next  = '{status: dcc_pkg::STATUS_RANGE, edge_present: 1'b0,
                                      same_component: 1'b0, component_a: '0,
                                      component_b: '0};
                        pend_next = 1'b1;
                    end else begin
                        adj_ctrl.rd_en = 1'b1;
                        adj_rd_addr    = in_a[IW-1:0];
                        lbl_ctrl.rd_en = 1'b1;
                        state_next     = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                la_next = lbl_rd0_data;
                lb_next = lbl_rd1_data;
                if ((mode_reg == dcc_pkg::MODE_INSERT && !present) ||
                    (mode_reg == dcc_pkg::MODE_REMOVE && present)) begin
                    adj_ctrl.wr_en = 1'b1;
                    if (mode_reg == dcc_pkg::MODE_INSERT) begin
                        adj_wr_data = adj_rd_data | (ONE << b_reg[IW-1:0]);
                        edges_next  = edges_reg + EW'(1);
                    end else begin
                        adj_wr_data = adj_rd_data & ~(ONE << b_reg[IW-1:0]);
                        if (edges_reg != '0) begin
                            edges_next = edges_reg - EW'(1);
                        end
                    end
                    state_next = S_ROWB_RD;
                end else begin
                    res_next.status = (mode_reg == dcc_pkg::MODE_INSERT ||
                                       mode_reg == dcc_pkg::MODE_REMOVE) ?
                                      dcc_pkg::STATUS_NO_CHANGE : dcc_pkg::STATUS_DONE;
                    res_next.edge_present   = present;
                    res_next.same_component = (lbl_rd0_data == lbl_rd1_data);
                    res_next.component_a    = lbl_rd0_data;
                    res_next.component_b    = lbl_rd1_data;
                    pend_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_ROWB_RD: begin
                adj_ctrl.rd_en = 1'b1;
                adj_rd_addr    = b_reg[IW-1:0];
                state_next     = S_ROWB_WR;
            end
            S_ROWB_WR: begin
                // Set or clear, so a self loop that already hit this row stays put.
                adj_ctrl.wr_en = 1'b1;
                adj_wr_addr    = b_reg[IW-1:0];
                adj_wr_data    = (mode_reg == dcc_pkg::MODE_INSERT) ?
                                 (adj_rd_data | (ONE << a_reg[IW-1:0])) :
                                 (adj_rd_data & ~(ONE << a_reg[IW-1:0]));
                idx_next       = '0;
                if (mode_reg == dcc_pkg::MODE_INSERT) begin
                    if (la_reg != lb_reg) begin
                        state_next = S_MRD;
                    end else begin
                        res_next   = '{status: dcc_pkg::STATUS_DONE, edge_present: 1'b1,
                                       same_component: 1'b1, component_a: la_reg,
                                       component_b: lb_reg};
                        pend_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end else begin
                    visited_next  = ONE << a_reg[IW-1:0];
                    expanded_next = '0;
                    state_next    = S_PICK;
                end
            end
            S_MRD: begin
                if (scan_end) begin
                    if (comp_reg != '0) begin
                        comp_next = comp_reg - NW'(1);
                    end
                    res_next   = '{status: dcc_pkg::STATUS_DONE, edge_present: 1'b1,
                                   same_component: 1'b1, component_a: lab_lo,
                                   component_b: lab_lo};
                    pend_next  = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    lbl_ctrl.rd_en = 1'b1;
                    lbl_rd0_addr   = idx_reg[IW-1:0];
                    state_next     = S_MWR;
                end
            end
            S_MWR: begin
                // Fold the higher label into the lower, move the top label down.
                if (lbl_rd0_data == lab_hi) begin
                    lbl_ctrl.wr_en = 1'b1;
                    lbl_wr_data    = lab_lo;
                end else if (NW'(lbl_rd0_data) + NW'(1) == comp_reg) begin
                    lbl_ctrl.wr_en = 1'b1;
                    lbl_wr_data    = lab_hi;
                end
                idx_next   = idx_reg + CW'(1);
                state_next = S_MRD;
            end
            S_PICK: begin
                if (pick_any) begin
                    expanded_next = expanded_reg | (ONE << pick_idx);
                    adj_ctrl.rd_en = 1'b1;
                    adj_rd_addr    = pick_idx;
                    state_next     = S_OR;
                end else if (visited_reg[b_reg[IW-1:0]]) begin
                    res_next   = '{status: dcc_pkg::STATUS_DONE, edge_present: 1'b0,
                                   same_component: (la_reg == lb_reg), component_a: la_reg,
                                   component_b: lb_reg};
                    pend_next  = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    state_next = S_RELAB;
                end
            end
            S_OR: begin
                visited_next = visited_reg | adj_rd_data;
                state_next   = S_PICK;
            end
            S_RELAB: begin
                if (scan_end) begin
                    comp_next  = comp_reg + NW'(1);
                    res_next   = '{status: dcc_pkg::STATUS_DONE, edge_present: 1'b0,
                                   same_component: (comp_reg[LW-1:0] == lb_reg),
                                   component_a: comp_reg[LW-1:0], component_b: lb_reg};
                    pend_next  = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    if (visited_reg[idx_reg[IW-1:0]]) begin
                        lbl_ctrl.wr_en = 1'b1;
                        lbl_wr_data    = comp_reg[LW-1:0];
                    end
                    idx_next = idx_reg + CW'(1);
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Hand the staged result to the output register once it is free.
        if (pend_reg && (!out_valid_reg || m_tready)) begin
            out_valid_next = 1'b1;
            out_data_next  = {5'b0, edges_reg, comp_reg, res_reg.component_b,
                              res_reg.component_a, res_reg.same_component,
                              res_reg.edge_present, res_reg.status};
            pend_next      = 1'b0;
        end

        if (cfg_we) begin
            vc_next        = cfg_vc;
            comp_next      = cfg_vc;
            edges_next     = '0;
            adj_ctrl.clear = 1'b1;
            lbl_ctrl.clear = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            vc_reg        <= NW'(VLIM);
            comp_reg      <= NW'(VLIM);
            edges_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            vc_reg        <= vc_next;
            comp_reg      <= comp_next;
            edges_reg     <= edges_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg     <= mode_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        la_reg       <= la_next;
        lb_reg       <= lb_next;
        idx_reg      <= idx_next;
        visited_reg  <= visited_next;
        expanded_reg <= expanded_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    dcc_adj_mem #(.DEPTH(VLIM)) u_adj (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (adj_ctrl),
        .rd_addr (adj_rd_addr),
        .wr_addr (adj_wr_addr),
        .wr_data (adj_wr_data),
        .rd_data (adj_rd_data)
    );

    dcc_label_mem #(.DEPTH(VLIM)) u_lbl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (lbl_ctrl),
        .rd0_addr (lbl_rd0_addr),
        .rd1_addr (lbl_rd1_addr),
        .wr_addr  (lbl_wr_addr),
        .wr_data  (lbl_wr_data),
        .rd0_data (lbl_rd0_data),
        .rd1_data (lbl_rd1_data)
    );
endmodule
`default_nettype wire

// ----- sv/dcc_checker.sv -----
`default_nettype none
`include "dynamic_connected_components_unit_defines.svh"
module dcc_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [39:0] m_tdata
);
    `DCC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `DCC_ASSERT_NOW(a_status_code, m_tvalid, m_tdata[1:0] <= dcc_pkg::STATUS_RANGE)
    `DCC_ASSERT_NOW(a_range_zero, m_tvalid && m_tdata[1:0] == dcc_pkg::STATUS_RANGE, m_tdata[15:2] == 14'd0)
    `DCC_ASSERT_NOW(a_edge_joins, m_tvalid && m_tdata[2], m_tdata[3])
    `DCC_ASSERT_NOW(a_same_label, m_tvalid && m_tdata[1:0] != dcc_pkg::STATUS_RANGE, m_tdata[3] == (m_tdata[9:4] == m_tdata[15:10]))
endmodule

bind dynamic_connected_components_unit dcc_checker u_dcc_checker (.*);
`default_nettype wire

// ----- test/dynamic_connected_components_unit_tb.sv -----
`default_nettype none
module dynamic_connected_components_unit_tb;

    localparam int WATCHDOG_CYCLES = 20000;
    localparam int DRAIN_CYCLES    = 400;

    // same bit order as s_tdata[13:0]
    typedef struct packed {
        logic [5:0] vb;
        logic [5:0] va;
        logic [1:0] mode;
    } edge_op_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        edge_present;
        logic        same_component;
        logic [5:0]  comp_a;
        logic [5:0]  comp_b;
        logic [6:0]  comp_total;
        logic [11:0] edge_total;
    } cc_report_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [15:0] s_tdata = '0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [39:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire  [31:0] prdata;
    wire         pready;

    dynamic_connected_components_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 aclk = ~aclk;

    // graph shadow
    logic [63:0] adj_rows [64];
    logic [5:0]  labels [64];
    int          n_vert;
    int          n_comp;
    int          n_edge;

    edge_op_t   pending_ops[$];
    cc_report_t expected_reports[$];
    int  mismatches = 0;
    int  accepted_in = 0;
    int  accepted_out = 0;
    int  idle_cycles = 0;
    bit  quiet_phase = 1'b0;
    bit  timed_out = 1'b0;

    function automatic void reset_graph(int count);
        n_vert = count;
        n_comp = count;
        n_edge = 0;
        for (int i = 0; i < 64; i++) begin
            adj_rows[i] = '0;
            labels[i] = 6'(i);
        end
    endfunction

    function automatic cc_report_t apply_edge_op(edge_op_t op);
        cc_report_t r;
        int a, b, lo, hi;
        logic [63:0] seen;
        int stack[$];
        int v;
        logic present;
        r = '0;
        a = op.va;
        b = op.vb;
        if (a >= n_vert || b >= n_vert) begin
            r.status = dcc_pkg::STATUS_RANGE;
            r.comp_total = 7'(n_comp);
            r.edge_total = 12'(n_edge);
            return r;
        end
        r.status = dcc_pkg::STATUS_DONE;
        present = adj_rows[a][b];
        if (op.mode == dcc_pkg::MODE_INSERT) begin
            if (present) begin
                r.status = dcc_pkg::STATUS_NO_CHANGE;
            end else begin
                adj_rows[a][b] = 1'b1;
                adj_rows[b][a] = 1'b1;
                n_edge++;
                if (labels[a] != labels[b]) begin
                    lo = (labels[a] < labels[b]) ? labels[a] : labels[b];
                    hi = (labels[a] < labels[b]) ? labels[b] : labels[a];
                    for (int i = 0; i < n_vert; i++) begin
                        if (labels[i] == hi) labels[i] = 6'(lo);
                        else if (labels[i] + 1 == n_comp) labels[i] = 6'(hi);
                    end
                    if (n_comp > 0) n_comp--;
                end
            end
        end else if (op.mode == dcc_pkg::MODE_REMOVE) begin
            if (!present) begin
                r.status = dcc_pkg::STATUS_NO_CHANGE;
            end else begin
                adj_rows[a][b] = 1'b0;
                adj_rows[b][a] = 1'b0;
                if (n_edge > 0) n_edge--;
                seen = '0;
                seen[a] = 1'b1;
                stack.push_back(a);
                while (stack.size() > 0) begin
                    v = stack.pop_back();
                    for (int w = 0; w < n_vert; w++) begin
                        if (adj_rows[v][w] && !seen[w]) begin
                            seen[w] = 1'b1;
                            stack.push_back(w);
                        end
                    end
                end
                if (!seen[b]) begin
                    for (int i = 0; i < n_vert; i++)
                        if (seen[i]) labels[i] = 6'(n_comp);
                    n_comp++;
                end
            end
        end
        r.edge_present = adj_rows[a][b];
        r.same_component = labels[a] == labels[b];
        r.comp_a = labels[a];
        r.comp_b = labels[b];
        r.comp_total = 7'(n_comp);
        r.edge_total = 12'(n_edge);
        return r;
    endfunction

    function automatic logic chance_idle();
        return !quiet_phase && ($urandom_range(0, 99) < 6);
    endfunction

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready) begin
                if (s_tvalid && s_tready) begin
                    accepted_in++;
                    expected_reports.push_back(apply_edge_op(s_tdata[13:0]));
                end
                if (pending_ops.size() > 0 && !chance_idle()) begin
                    edge_op_t op;
                    op = pending_ops.pop_front();
                    s_tdata <= {2'b00, op.vb, op.va, op.mode};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                cc_report_t got, want;
                got = '{status: m_tdata[1:0], edge_present: m_tdata[2],
                        same_component: m_tdata[3], comp_a: m_tdata[9:4],
                        comp_b: m_tdata[15:10], comp_total: m_tdata[22:16],
                        edge_total: m_tdata[34:23]};
                accepted_out++;
                if (expected_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %p", got);
                end else begin
                    want = expected_reports.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p got %p", want, got);
                    end
                end
            end
            m_tready <= !chance_idle();
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge aclk) begin
        if (idle_cycles >= WATCHDOG_CYCLES && !timed_out) begin
            timed_out = 1'b1;
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_ops.size() > 0 || s_tvalid || expected_reports.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_vertex_count(int value);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'(4 * dcc_pkg::REG_VERTEX_COUNT);
        pwdata <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        reset_graph(value > 64 ? 64 : value);
    endtask

    function automatic void add_op(int mode, int a, int b);
        edge_op_t op;
        op.mode = 2'(mode);
        op.va = 6'(a);
        op.vb = 6'(b);
        pending_ops.push_back(op);
    endfunction

    // chains and rings so removals both split and keep components
    task automatic queue_random_phase(int items);
        int n, a, b, r;
        n = (n_vert < 1) ? 1 : n_vert;
        for (int i = 0; i < items; i++) begin
            r = $urandom_range(0, 99);
            a = $urandom_range(0, n - 1);
            b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1)
                                            : (a + 1) % n;
            if (r < 45) add_op(dcc_pkg::MODE_INSERT, a, b);
            else if (r < 75) add_op(dcc_pkg::MODE_REMOVE, a, b);
            else if (r < 90) add_op(dcc_pkg::MODE_QUERY, a, b);
            else add_op($urandom_range(0, 3), $urandom_range(0, 63), $urandom_range(0, 63));
        end
    endtask

    initial begin
        reset_graph(64);
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (3) @(posedge aclk);
        // directed: extremes, self loop, repeats, split, unused mode
        add_op(dcc_pkg::MODE_INSERT, 0, 63);
        add_op(dcc_pkg::MODE_INSERT, 0, 63);
        add_op(dcc_pkg::MODE_INSERT, 5, 5);
        add_op(dcc_pkg::MODE_REMOVE, 5, 5);
        add_op(dcc_pkg::MODE_REMOVE, 5, 5);
        add_op(dcc_pkg::MODE_INSERT, 63, 1);
        add_op(dcc_pkg::MODE_INSERT, 0, 1);
        add_op(dcc_pkg::MODE_REMOVE, 0, 63);
        add_op(dcc_pkg::MODE_REMOVE, 0, 1);
        add_op(dcc_pkg::MODE_QUERY, 63, 0);
        add_op(dcc_pkg::MODE_UNUSED, 1, 63);
        add_op(dcc_pkg::MODE_INSERT, 42, 21);
        wait_drained();
        write_vertex_count(100);
        add_op(dcc_pkg::MODE_INSERT, 63, 62);
        wait_drained();
        write_vertex_count(0);
        add_op(dcc_pkg::MODE_INSERT, 0, 0);
        add_op(dcc_pkg::MODE_QUERY, 0, 0);
        wait_drained();
        write_vertex_count(1);
        add_op(dcc_pkg::MODE_INSERT, 0, 0);
        add_op(dcc_pkg::MODE_INSERT, 0, 1);
        add_op(dcc_pkg::MODE_REMOVE, 0, 0);
        wait_drained();
        write_vertex_count(8);
        queue_random_phase(300);
        wait_drained();
        write_vertex_count(64);
        quiet_phase = 1'b1;
        queue_random_phase(250);
        wait_drained();
        quiet_phase = 1'b0;
        write_vertex_count(17);
        queue_random_phase(300);
        wait_drained();
        write_vertex_count(64);
        queue_random_phase(300);
        wait_drained();
        write_vertex_count(3);
        queue_random_phase(280);
        wait_drained();
        $display("covered %0d items and %0d results over vertex counts 0 to 64",
                 accepted_in, accepted_out);
        $display("inserts, removals with split search, queries and range errors");
        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire
